// ===== rtl/lslf_pkg.sv =====
// Shared constants, status codes and width helpers for the least-squares line fit.
// No dependencies; imported by every module of the block.
package lslf_pkg;

   localparam int LSLF_MAX_POINTS  = 64;
   localparam int LSLF_QUEUE_DEPTH = 2;

   localparam logic [1:0] LSLF_ST_OK        = 2'd0;
   localparam logic [1:0] LSLF_ST_ZERO_DEN  = 2'd1;
   localparam logic [1:0] LSLF_ST_TOO_MANY  = 2'd2;
   localparam logic [1:0] LSLF_ST_SATURATED = 2'd3;

   function automatic int lslf_cnt_w(int max_points);
      return $clog2(max_points + 1);
   endfunction

   function automatic int lslf_sum_w(int max_points);
      return 16 + $clog2(max_points);
   endfunction

   function automatic int lslf_prd_w(int max_points);
      return 32 + $clog2(max_points);
   endfunction

   function automatic int lslf_sq_w(int max_points);
      return 31 + $clog2(max_points);
   endfunction

   function automatic int lslf_snap_w(int max_points);
      return 1 + lslf_cnt_w(max_points) + 2 * lslf_sum_w(max_points)
             + lslf_prd_w(max_points) + lslf_sq_w(max_points);
   endfunction

endpackage

// ===== rtl/lslf_front.sv =====
// Front end: takes one point per cycle while take is high and keeps count and running sums.
// On the last point of a set it emits a packed snapshot. Depends on lslf_pkg.
module lslf_front
   import lslf_pkg::*;
#(
   parameter int MAX_POINTS = LSLF_MAX_POINTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 take,
   input  logic signed [15:0]                   x_value,
   input  logic signed [15:0]                   y_value,
   input  logic                                 last_point,
   output logic                                 snap_push,
   output logic [lslf_snap_w(MAX_POINTS)-1:0]   snap_data
);

   localparam int CNT_W = lslf_cnt_w(MAX_POINTS);
   localparam int SUM_W = lslf_sum_w(MAX_POINTS);
   localparam int PRD_W = lslf_prd_w(MAX_POINTS);
   localparam int SQ_W  = lslf_sq_w(MAX_POINTS);

   logic [CNT_W-1:0]        cnt_ff, cnt_in, cnt_acc;
   logic signed [SUM_W-1:0] sx_ff, sx_in, sx_acc;
   logic signed [SUM_W-1:0] sy_ff, sy_in, sy_acc;
   logic signed [PRD_W-1:0] sxy_ff, sxy_in, sxy_acc;
   logic [SQ_W-1:0]         sx2_ff, sx2_in, sx2_acc;
   logic                    ovf_ff, ovf_in, ovf_acc;
   logic signed [31:0]      xy_prod;
   logic signed [31:0]      xx_prod;

   assign xy_prod = x_value * y_value;
   assign xx_prod = x_value * x_value;

   always_comb begin
      cnt_acc = cnt_ff;
      sx_acc  = sx_ff;
      sy_acc  = sy_ff;
      sxy_acc = sxy_ff;
      sx2_acc = sx2_ff;
      ovf_acc = ovf_ff;
      if (cnt_ff >= CNT_W'(MAX_POINTS)) begin
         ovf_acc = 1'b1;
      end else begin
         cnt_acc = cnt_ff + 1'b1;
         sx_acc  = sx_ff + SUM_W'(x_value);
         sy_acc  = sy_ff + SUM_W'(y_value);
         sxy_acc = sxy_ff + PRD_W'(xy_prod);
         sx2_acc = sx2_ff + SQ_W'(xx_prod[30:0]);
      end

      cnt_in = cnt_ff;
      sx_in  = sx_ff;
      sy_in  = sy_ff;
      sxy_in = sxy_ff;
      sx2_in = sx2_ff;
      ovf_in = ovf_ff;
      if (take) begin
         if (last_point) begin
            cnt_in = '0;
            sx_in  = '0;
            sy_in  = '0;
            sxy_in = '0;
            sx2_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = cnt_acc;
            sx_in  = sx_acc;
            sy_in  = sy_acc;
            sxy_in = sxy_acc;
            sx2_in = sx2_acc;
            ovf_in = ovf_acc;
         end
      end
   end

   assign snap_push = take & last_point;
   assign snap_data = {ovf_acc, cnt_acc, sx_acc, sy_acc, sxy_acc, sx2_acc};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxy_ff <= '0;
         sx2_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         sx_ff  <= sx_in;
         sy_ff  <= sy_in;
         sxy_ff <= sxy_in;
         sx2_ff <= sx2_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

// ===== rtl/lslf_queue.sv =====
// Short snapshot queue between front and back end.
// Depth from lslf_pkg; payload width set by the instantiating module.
module lslf_queue
   import lslf_pkg::*;
#(
   parameter int DATA_W = lslf_snap_w(LSLF_MAX_POINTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] data_in,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output logic [DATA_W-1:0] data_out
);

   localparam int DEPTH = LSLF_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign data_out = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ===== rtl/lslf_back.sv =====
// Back end: digit-serial products into three accumulators, then a shared
// restoring divider for slope and intercept, and a one-entry result register.
// Depends on lslf_pkg.
module lslf_back
   import lslf_pkg::*;
#(
   parameter int MAX_POINTS = LSLF_MAX_POINTS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 snap_empty,
   input  logic [lslf_snap_w(MAX_POINTS)-1:0]   snap_data,
   output logic                                 snap_pop,
   output logic                                 empty,
   input  logic                                 pop,
   output logic signed [31:0]                   slope,
   output logic signed [31:0]                   intercept,
   output logic [1:0]                           status
);

   localparam int LG     = $clog2(MAX_POINTS);
   localparam int CNT_W  = lslf_cnt_w(MAX_POINTS);
   localparam int SUM_W  = lslf_sum_w(MAX_POINTS);
   localparam int PRD_W  = lslf_prd_w(MAX_POINTS);
   localparam int SQ_W   = lslf_sq_w(MAX_POINTS);
   localparam int SNAP_W = lslf_snap_w(MAX_POINTS);
   localparam int MAG_W  = 31 + LG;
   localparam int B_W    = SUM_W;
   localparam int NDIG   = (B_W + 15) / 16;
   localparam int B_PAD  = NDIG * 16;
   localparam int DIG_W  = (NDIG > 1) ? $clog2(NDIG) : 1;
   localparam int PP_W   = MAG_W + 16;
   localparam int ACC_W  = 48 + 2 * LG;
   localparam int D_W    = 31 + 2 * LG;
   localparam int DIVN_W = ACC_W + 8;
   localparam int DC_W   = $clog2(DIVN_W);
   localparam int SLOPE_SHIFT = 16;
   localparam int ICPT_SHIFT  = 8;

   localparam int OFS_SXY = SQ_W;
   localparam int OFS_SY  = OFS_SXY + PRD_W;
   localparam int OFS_SX  = OFS_SY + SUM_W;
   localparam int OFS_CNT = OFS_SX + SUM_W;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_DRAIN = 3'd2;
   localparam logic [2:0] S_CHECK = 3'd3;
   localparam logic [2:0] S_PREP  = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_FIN   = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   // product terms: D = n*Sx2 - Sx*Sx, Ns = n*Sxy - Sx*Sy, Ni = Sx2*Sy - Sxy*Sx
   localparam logic [2:0] T_D_POS  = 3'd0;
   localparam logic [2:0] T_D_NEG  = 3'd1;
   localparam logic [2:0] T_NS_POS = 3'd2;
   localparam logic [2:0] T_NS_NEG = 3'd3;
   localparam logic [2:0] T_NI_POS = 3'd4;
   localparam logic [2:0] T_NI_NEG = 3'd5;

   localparam logic [1:0] ACC_D  = 2'd0;
   localparam logic [1:0] ACC_NS = 2'd1;
   localparam logic [1:0] ACC_NI = 2'd2;

   localparam logic DIV_SLOPE = 1'b0;
   localparam logic DIV_ICPT  = 1'b1;

   logic [2:0]              state_ff, state_in;

   logic [B_W-1:0]          n_ff, n_in;
   logic [B_W-1:0]          sx_mag_ff, sx_mag_in;
   logic [B_W-1:0]          sy_mag_ff, sy_mag_in;
   logic [MAG_W-1:0]        sxy_mag_ff, sxy_mag_in;
   logic [MAG_W-1:0]        sx2_ff, sx2_in;
   logic                    sx_neg_ff, sx_neg_in;
   logic                    sy_neg_ff, sy_neg_in;
   logic                    sxy_neg_ff, sxy_neg_in;

   logic [2:0]              term_ff, term_in;
   logic [DIG_W-1:0]        dig_ff, dig_in;
   logic [PP_W-1:0]         pp_ff, pp_in;
   logic                    pp_neg_ff, pp_neg_in;
   logic [DIG_W-1:0]        pp_dig_ff, pp_dig_in;
   logic [1:0]              pp_acc_ff, pp_acc_in;
   logic                    pp_vld_ff, pp_vld_in;

   logic signed [ACC_W-1:0] acc_d_ff, acc_d_in;
   logic signed [ACC_W-1:0] acc_ns_ff, acc_ns_in;
   logic signed [ACC_W-1:0] acc_ni_ff, acc_ni_in;

   logic                    div_sel_ff, div_sel_in;
   logic                    div_neg_ff, div_neg_in;
   logic [DIVN_W-1:0]       num_ff, num_in;
   logic [D_W-1:0]          rem_ff, rem_in;
   logic [32:0]             q_ff, q_in;
   logic                    big_ff, big_in;
   logic [DC_W-1:0]         dcnt_ff, dcnt_in;
   logic                    sat_ff, sat_in;

   logic signed [31:0]      res_slope_ff, res_slope_in;
   logic signed [31:0]      res_icpt_ff, res_icpt_in;
   logic [1:0]              res_status_ff, res_status_in;

   logic                    out_vld_ff, out_vld_in;
   logic signed [31:0]      out_slope_ff, out_slope_in;
   logic signed [31:0]      out_icpt_ff, out_icpt_in;
   logic [1:0]              out_status_ff, out_status_in;

   // snapshot fields and magnitudes
   logic                    s_ovf;
   logic [CNT_W-1:0]        s_cnt;
   logic [SUM_W-1:0]        s_sx, s_sy, s_sx_abs, s_sy_abs;
   logic [PRD_W-1:0]        s_sxy, s_sxy_abs;
   logic [SQ_W-1:0]         s_sx2;

   // multiplier
   logic [MAG_W-1:0]        a_sel;
   logic [B_W-1:0]          b_sel;
   logic                    t_neg;
   logic [1:0]              t_acc;
   logic [B_PAD-1:0]        b_pad;
   logic [15:0]             digit;
   logic [ACC_W-1:0]        addend;
   logic signed [ACC_W-1:0] acc_cur, acc_new;

   // divider
   logic [D_W-1:0]          dval;
   logic [D_W:0]            trial, diff;
   logic                    ge;
   logic signed [ACC_W-1:0] src;
   logic [ACC_W-1:0]        src_mag;
   logic                    sat_now;
   logic signed [31:0]      q_val;

   logic                    out_wr;

   assign s_sx2 = snap_data[SQ_W-1:0];
   assign s_sxy = snap_data[OFS_SXY +: PRD_W];
   assign s_sy  = snap_data[OFS_SY +: SUM_W];
   assign s_sx  = snap_data[OFS_SX +: SUM_W];
   assign s_cnt = snap_data[OFS_CNT +: CNT_W];
   assign s_ovf = snap_data[SNAP_W-1];

   assign s_sx_abs  = s_sx[SUM_W-1] ? (~s_sx + 1'b1) : s_sx;
   assign s_sy_abs  = s_sy[SUM_W-1] ? (~s_sy + 1'b1) : s_sy;
   assign s_sxy_abs = s_sxy[PRD_W-1] ? (~s_sxy + 1'b1) : s_sxy;

   always_comb begin
      a_sel = '0;
      b_sel = '0;
      t_neg = 1'b0;
      t_acc = ACC_D;
      unique case (term_ff)
         T_D_POS: begin
            a_sel = sx2_ff;
            b_sel = n_ff;
            t_neg = 1'b0;
            t_acc = ACC_D;
         end
         T_D_NEG: begin
            a_sel = MAG_W'(sx_mag_ff);
            b_sel = sx_mag_ff;
            t_neg = 1'b1;
            t_acc = ACC_D;
         end
         T_NS_POS: begin
            a_sel = sxy_mag_ff;
            b_sel = n_ff;
            t_neg = sxy_neg_ff;
            t_acc = ACC_NS;
         end
         T_NS_NEG: begin
            a_sel = MAG_W'(sx_mag_ff);
            b_sel = sy_mag_ff;
            t_neg = ~(sx_neg_ff ^ sy_neg_ff);
            t_acc = ACC_NS;
         end
         T_NI_POS: begin
            a_sel = sx2_ff;
            b_sel = sy_mag_ff;
            t_neg = sy_neg_ff;
            t_acc = ACC_NI;
         end
         T_NI_NEG: begin
            a_sel = sxy_mag_ff;
            b_sel = sx_mag_ff;
            t_neg = ~(sxy_neg_ff ^ sx_neg_ff);
            t_acc = ACC_NI;
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
            t_neg = 1'b0;
            t_acc = ACC_D;
         end
      endcase
   end

   assign b_pad  = B_PAD'(b_sel);
   assign digit  = b_pad[dig_ff * 16 +: 16];
   assign addend = ACC_W'(pp_ff) << {pp_dig_ff, 4'b0000};

   always_comb begin
      unique case (pp_acc_ff)
         ACC_D:   acc_cur = acc_d_ff;
         ACC_NS:  acc_cur = acc_ns_ff;
         ACC_NI:  acc_cur = acc_ni_ff;
         default: acc_cur = acc_d_ff;
      endcase
      acc_new = pp_neg_ff ? (acc_cur - $signed(addend)) : (acc_cur + $signed(addend));
   end

   assign dval    = acc_d_ff[D_W-1:0];
   assign trial   = {rem_ff, num_ff[DIVN_W-1]};
   assign diff    = trial - {1'b0, dval};
   assign ge      = (trial >= {1'b0, dval});
   assign src     = (div_sel_ff == DIV_ICPT) ? acc_ni_ff : acc_ns_ff;
   assign src_mag = src[ACC_W-1] ? (~src + 1'b1) : src;
   assign sat_now = div_neg_ff ? (big_ff | q_ff[32] | (q_ff[31] & (|q_ff[30:0])))
                               : (big_ff | q_ff[32] | q_ff[31]);

   always_comb begin
      if (div_neg_ff) begin
         q_val = sat_now ? 32'sh8000_0000 : $signed(~q_ff[31:0] + 1'b1);
      end else begin
         q_val = sat_now ? 32'sh7FFF_FFFF : $signed(q_ff[31:0]);
      end
   end

   assign out_wr = (state_ff == S_OUT) && (!out_vld_ff || pop);

   always_comb begin
      state_in      = state_ff;
      snap_pop      = 1'b0;
      n_in          = n_ff;
      sx_mag_in     = sx_mag_ff;
      sy_mag_in     = sy_mag_ff;
      sxy_mag_in    = sxy_mag_ff;
      sx2_in        = sx2_ff;
      sx_neg_in     = sx_neg_ff;
      sy_neg_in     = sy_neg_ff;
      sxy_neg_in    = sxy_neg_ff;
      term_in       = term_ff;
      dig_in        = dig_ff;
      pp_in         = pp_ff;
      pp_neg_in     = pp_neg_ff;
      pp_dig_in     = pp_dig_ff;
      pp_acc_in     = pp_acc_ff;
      pp_vld_in     = 1'b0;
      acc_d_in      = acc_d_ff;
      acc_ns_in     = acc_ns_ff;
      acc_ni_in     = acc_ni_ff;
      div_sel_in    = div_sel_ff;
      div_neg_in    = div_neg_ff;
      num_in        = num_ff;
      rem_in        = rem_ff;
      q_in          = q_ff;
      big_in        = big_ff;
      dcnt_in       = dcnt_ff;
      sat_in        = sat_ff;
      res_slope_in  = res_slope_ff;
      res_icpt_in   = res_icpt_ff;
      res_status_in = res_status_ff;

      if (pp_vld_ff) begin
         unique case (pp_acc_ff)
            ACC_D:   acc_d_in  = acc_new;
            ACC_NS:  acc_ns_in = acc_new;
            ACC_NI:  acc_ni_in = acc_new;
            default: acc_d_in  = acc_d_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (!snap_empty) begin
               snap_pop   = 1'b1;
               n_in       = B_W'(s_cnt);
               sx_mag_in  = s_sx_abs;
               sy_mag_in  = s_sy_abs;
               sxy_mag_in = s_sxy_abs[MAG_W-1:0];
               sx2_in     = MAG_W'(s_sx2);
               sx_neg_in  = s_sx[SUM_W-1];
               sy_neg_in  = s_sy[SUM_W-1];
               sxy_neg_in = s_sxy[PRD_W-1];
               acc_d_in   = '0;
               acc_ns_in  = '0;
               acc_ni_in  = '0;
               term_in    = T_D_POS;
               dig_in     = '0;
               if (s_ovf) begin
                  res_slope_in  = '0;
                  res_icpt_in   = '0;
                  res_status_in = LSLF_ST_TOO_MANY;
                  state_in      = S_OUT;
               end else begin
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            pp_in     = a_sel * digit;
            pp_neg_in = t_neg;
            pp_dig_in = dig_ff;
            pp_acc_in = t_acc;
            pp_vld_in = 1'b1;
            if (dig_ff == DIG_W'(NDIG - 1)) begin
               dig_in  = '0;
               term_in = term_ff + 1'b1;
               if (term_ff == T_NI_NEG) begin
                  state_in = S_DRAIN;
               end
            end else begin
               dig_in = dig_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (acc_d_ff == '0) begin
               res_slope_in  = '0;
               res_icpt_in   = '0;
               res_status_in = LSLF_ST_ZERO_DEN;
               state_in      = S_OUT;
            end else begin
               div_sel_in = DIV_SLOPE;
               sat_in     = 1'b0;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            div_neg_in = src[ACC_W-1];
            num_in     = (div_sel_ff == DIV_ICPT) ? (DIVN_W'(src_mag) << ICPT_SHIFT)
                                                  : (DIVN_W'(src_mag) << SLOPE_SHIFT);
            rem_in     = '0;
            q_in       = '0;
            big_in     = 1'b0;
            dcnt_in    = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            rem_in  = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            num_in  = num_ff << 1;
            q_in    = {q_ff[31:0], ge};
            big_in  = big_ff | q_ff[32];
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DC_W'(DIVN_W - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (div_sel_ff == DIV_SLOPE) begin
               res_slope_in = q_val;
               sat_in       = sat_now;
               div_sel_in   = DIV_ICPT;
               state_in     = S_PREP;
            end else begin
               res_icpt_in   = q_val;
               res_status_in = (sat_ff | sat_now) ? LSLF_ST_SATURATED : LSLF_ST_OK;
               state_in      = S_OUT;
            end
         end
         S_OUT: begin
            if (out_wr) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_vld_in    = out_vld_ff;
      out_slope_in  = out_slope_ff;
      out_icpt_in   = out_icpt_ff;
      out_status_in = out_status_ff;
      if (out_wr) begin
         out_vld_in    = 1'b1;
         out_slope_in  = res_slope_ff;
         out_icpt_in   = res_icpt_ff;
         out_status_in = res_status_ff;
      end else if (pop && out_vld_ff) begin
         out_vld_in = 1'b0;
      end
   end

   assign empty     = ~out_vld_ff;
   assign slope     = out_slope_ff;
   assign intercept = out_icpt_ff;
   assign status    = out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pp_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pp_vld_ff  <= pp_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      sx_mag_ff     <= sx_mag_in;
      sy_mag_ff     <= sy_mag_in;
      sxy_mag_ff    <= sxy_mag_in;
      sx2_ff        <= sx2_in;
      sx_neg_ff     <= sx_neg_in;
      sy_neg_ff     <= sy_neg_in;
      sxy_neg_ff    <= sxy_neg_in;
      term_ff       <= term_in;
      dig_ff        <= dig_in;
      pp_ff         <= pp_in;
      pp_neg_ff     <= pp_neg_in;
      pp_dig_ff     <= pp_dig_in;
      pp_acc_ff     <= pp_acc_in;
      acc_d_ff      <= acc_d_in;
      acc_ns_ff     <= acc_ns_in;
      acc_ni_ff     <= acc_ni_in;
      div_sel_ff    <= div_sel_in;
      div_neg_ff    <= div_neg_in;
      num_ff        <= num_in;
      rem_ff        <= rem_in;
      q_ff          <= q_in;
      big_ff        <= big_in;
      dcnt_ff       <= dcnt_in;
      sat_ff        <= sat_in;
      res_slope_ff  <= res_slope_in;
      res_icpt_ff   <= res_icpt_in;
      res_status_ff <= res_status_in;
      out_slope_ff  <= out_slope_in;
      out_icpt_ff   <= out_icpt_in;
      out_status_ff <= out_status_in;
   end

endmodule

// ===== rtl/least_squares_line_fit.sv =====
// Least-squares line fit. Points: one transfer per cycle while full is low; full rises only
// while the snapshot queue is full. Slope and intercept come from the one-bit-per-cycle
// restoring divider, run twice, first for the slope and then for the intercept. Sets with
// too many points skip the products and the divider; a zero denominator skips the divider.
// Synchronous reset clears sums, queue and result.
// Depends on lslf_pkg, lslf_front, lslf_queue, lslf_back.
module least_squares_line_fit
   import lslf_pkg::*;
#(
   parameter int MAX_POINTS = LSLF_MAX_POINTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic signed [15:0] req_x_value,
   input  logic signed [15:0] req_y_value,
   input  logic               req_last_point,
   output logic               empty,
   input  logic               pop,
   output logic signed [31:0] rsp_slope,
   output logic signed [31:0] rsp_intercept,
   output logic [1:0]         rsp_status
);

   localparam int SNAP_W = lslf_snap_w(MAX_POINTS);

   logic              take;
   logic              snap_push;
   logic [SNAP_W-1:0] snap_wdata;
   logic [SNAP_W-1:0] snap_rdata;
   logic              snap_empty;
   logic              snap_pop;

   assign take = push & ~full;

   lslf_front #(
      .MAX_POINTS (MAX_POINTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .x_value    (req_x_value),
      .y_value    (req_y_value),
      .last_point (req_last_point),
      .snap_push  (snap_push),
      .snap_data  (snap_wdata)
   );

   lslf_queue #(
      .DATA_W (SNAP_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (snap_push),
      .data_in  (snap_wdata),
      .full     (full),
      .pop      (snap_pop),
      .empty    (snap_empty),
      .data_out (snap_rdata)
   );

   lslf_back #(
      .MAX_POINTS (MAX_POINTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_empty (snap_empty),
      .snap_data  (snap_rdata),
      .snap_pop   (snap_pop),
      .empty      (empty),
      .pop        (pop),
      .slope      (rsp_slope),
      .intercept  (rsp_intercept),
      .status     (rsp_status)
   );

endmodule
